// ===== rtl/core/skwa_pkg.sv =====
// Package for the stack code keyword assembler.
// Holds item types, status and kind codes, character codes and keyword tables.
// No dependencies.
package skwa_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       finish;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] code_byte;
        logic [1:0] status;
        logic [7:0] code_count;
        logic       last;
    } t_out_item;

    // Results produced by one accepted item, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_emit;

    localparam logic KIND_CODE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CAP  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_NO_SPACE = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam int KW_NUM = 5;
    localparam int KW_LOAD = 0;
    localparam int KW_CONST = 1;

    localparam logic [1:0] AWAIT_NONE  = 2'd0;
    localparam logic [1:0] AWAIT_LOAD  = 2'd1;
    localparam logic [1:0] AWAIT_CONST = 2'd2;

    localparam logic [7:0] OP_LOAD   = 8'h00;
    localparam logic [7:0] OP_CONST  = 8'h20;
    localparam logic [4:0] KW_ALL    = 5'h1F;
    localparam logic [2:0] KW_POS_MAX = 3'd7;

    // Keyword spellings, padded with zero bytes to eight positions.
    localparam logic [7:0] KW_CHAR [KW_NUM][8] = '{
        '{8'h6C, 8'h6F, 8'h61, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},  // load
        '{8'h63, 8'h6F, 8'h6E, 8'h73, 8'h74, 8'h00, 8'h00, 8'h00},  // const
        '{8'h61, 8'h64, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // add
        '{8'h73, 8'h75, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // sub
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00}   // return
    };

    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd5, 3'd3, 3'd3, 3'd6};

    localparam logic [7:0] KW_CODE [KW_NUM] = '{8'h00, 8'h20, 8'h30, 8'h40, 8'h50};

    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/skwa_stream_if.sv =====
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; no other dependencies.
interface skwa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/skwa_scan.sv =====
// Scanner for the keyword assembler: token state, keyword match, argument decode.
// Produces up to two results per accepted item. Depends on skwa_pkg.
module skwa_scan #(
    parameter int MAX_TEXT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_accept,
    input  skwa_pkg::t_in_item i_item,
    output skwa_pkg::t_emit   o_emit
);
    import skwa_pkg::*;

    localparam int TL_W = $clog2(MAX_TEXT + 1);
    localparam logic [TL_W-1:0] TL_MAX = TL_W'(MAX_TEXT);

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_WORD,
        PH_ARG_LEAD,
        PH_ARG_DIGITS,
        PH_ARG_DONE
    } t_phase;

    logic [7:0]      r_cap;
    logic [TL_W-1:0] r_len,   n_len;
    t_phase          r_phase, n_phase;
    logic [4:0]      r_cand,  n_cand;
    logic [2:0]      r_pos,   n_pos;
    logic [1:0]      r_await, n_await;
    logic            r_neg,   n_neg;
    logic [3:0]      r_nib,   n_nib;
    logic [7:0]      r_count, n_count;
    logic            r_exh,   n_exh;
    logic            r_term,  n_term;

    logic            do_end;
    logic            emit_req;
    logic [7:0]      emit_byte;
    logic            em_valid;
    logic            found;
    logic [3:0]      arg_val;
    logic            is_sep;
    logic            is_digit;
    logic [1:0]      st;
    t_phase          ph;
    t_out_item       code_item;
    t_out_item       stat_item;

    assign is_sep = (i_item.symbol == CH_SPACE) || (i_item.symbol == CH_TAB) ||
                    (i_item.symbol == CH_LF) || (i_item.symbol == CH_CR) ||
                    (i_item.symbol == CH_SEMI);
    assign is_digit = (i_item.symbol >= CH_ZERO) && (i_item.symbol <= CH_NINE);

    always_comb begin
        n_len     = r_len;
        n_phase   = r_phase;
        n_cand    = r_cand;
        n_pos     = r_pos;
        n_await   = r_await;
        n_neg     = r_neg;
        n_nib     = r_nib;
        n_count   = r_count;
        n_exh     = r_exh;
        n_term    = r_term;
        do_end    = 1'b0;
        emit_req  = 1'b0;
        emit_byte = 8'h00;
        em_valid  = 1'b0;
        found     = 1'b0;
        arg_val   = 4'h0;
        ph        = r_phase;
        st        = ST_OK;

        if (i_accept) begin
            if (i_item.finish) begin
                do_end = !r_term;
            end else if (!r_term) begin
                if (i_item.symbol == CH_NUL) begin
                    n_term = 1'b1;
                    do_end = 1'b1;
                end else begin
                    if (r_len < TL_MAX) begin
                        n_len = r_len + 1'b1;
                    end
                    if (is_sep) begin
                        do_end = 1'b1;
                    end else begin
                        // Token character: the first one picks word or argument.
                        if (ph == PH_BETWEEN) begin
                            ph = (r_await != AWAIT_NONE) ? PH_ARG_LEAD : PH_WORD;
                        end
                        n_phase = ph;
                        case (ph)
                            PH_WORD: begin
                                for (int i = 0; i < KW_NUM; i++) begin
                                    if (r_pos >= KW_LEN[i] ||
                                        i_item.symbol != KW_CHAR[i][r_pos]) begin
                                        n_cand[i] = 1'b0;
                                    end
                                end
                                if (r_pos < KW_POS_MAX) begin
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                            PH_ARG_LEAD: begin
                                if (i_item.symbol == CH_VT || i_item.symbol == CH_FF) begin
                                    n_phase = PH_ARG_LEAD;
                                end else if (i_item.symbol == CH_PLUS ||
                                             i_item.symbol == CH_MINUS) begin
                                    n_neg   = (i_item.symbol == CH_MINUS);
                                    n_phase = PH_ARG_DIGITS;
                                end else if (is_digit) begin
                                    n_nib   = {r_nib[0], 3'b000} + {r_nib[2:0], 1'b0} +
                                              i_item.symbol[3:0];
                                    n_phase = PH_ARG_DIGITS;
                                end else begin
                                    n_phase = PH_ARG_DONE;
                                end
                            end
                            PH_ARG_DIGITS: begin
                                if (is_digit) begin
                                    n_nib = {r_nib[0], 3'b000} + {r_nib[2:0], 1'b0} +
                                            i_item.symbol[3:0];
                                end else begin
                                    n_phase = PH_ARG_DONE;
                                end
                            end
                            default: begin
                                n_phase = ph;
                            end
                        endcase
                    end
                end
            end

            if (do_end) begin
                if (r_phase == PH_WORD) begin
                    for (int i = 0; i < KW_NUM; i++) begin
                        if (!found && r_cand[i] && r_pos == KW_LEN[i]) begin
                            found = 1'b1;
                            if (i == KW_LOAD) begin
                                n_await = AWAIT_LOAD;
                            end else if (i == KW_CONST) begin
                                n_await = AWAIT_CONST;
                            end else begin
                                emit_req  = 1'b1;
                                emit_byte = KW_CODE[i];
                            end
                        end
                    end
                end else if (r_phase != PH_BETWEEN) begin
                    arg_val   = r_neg ? (4'h0 - r_nib) : r_nib;
                    emit_byte = ((r_await == AWAIT_CONST) ? OP_CONST : OP_LOAD) |
                                {4'h0, arg_val};
                    emit_req  = 1'b1;
                    n_await   = AWAIT_NONE;
                end
                n_phase = PH_BETWEEN;
                n_cand  = KW_ALL;
                n_pos   = 3'd0;
                n_neg   = 1'b0;
                n_nib   = 4'h0;
            end

            // Emission is dropped once the text is too long or space ran out.
            if (emit_req && n_len < TL_MAX && !r_exh) begin
                if (r_count >= r_cap) begin
                    n_exh = 1'b1;
                end else begin
                    n_count  = r_count + 1'b1;
                    em_valid = 1'b1;
                end
            end

            if (r_cap == 8'd0) begin
                st = ST_BAD_CAP;
            end else if (n_len >= TL_MAX) begin
                st = ST_TOO_LONG;
            end else if (n_exh) begin
                st = ST_NO_SPACE;
            end else begin
                st = ST_OK;
            end
        end
    end

    always_comb begin
        code_item.kind       = KIND_CODE;
        code_item.code_byte  = emit_byte;
        code_item.status     = ST_OK;
        code_item.code_count = n_count;
        code_item.last       = !(i_accept && i_item.finish);
        stat_item.kind       = KIND_STATUS;
        stat_item.code_byte  = 8'h00;
        stat_item.status     = st;
        stat_item.code_count = n_count;
        stat_item.last       = 1'b1;

        o_emit.count  = {1'b0, em_valid} + {1'b0, i_accept && i_item.finish};
        o_emit.first  = em_valid ? code_item : stat_item;
        o_emit.second = stat_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 8'hFF;
            r_len   <= '0;
            r_phase <= PH_BETWEEN;
            r_cand  <= KW_ALL;
            r_pos   <= 3'd0;
            r_await <= AWAIT_NONE;
            r_neg   <= 1'b0;
            r_nib   <= 4'h0;
            r_count <= 8'd0;
            r_exh   <= 1'b0;
            r_term  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_accept && i_item.finish) begin
                r_len   <= '0;
                r_phase <= PH_BETWEEN;
                r_cand  <= KW_ALL;
                r_pos   <= 3'd0;
                r_await <= AWAIT_NONE;
                r_neg   <= 1'b0;
                r_nib   <= 4'h0;
                r_count <= 8'd0;
                r_exh   <= 1'b0;
                r_term  <= 1'b0;
            end else begin
                r_len   <= n_len;
                r_phase <= n_phase;
                r_cand  <= n_cand;
                r_pos   <= n_pos;
                r_await <= n_await;
                r_neg   <= n_neg;
                r_nib   <= n_nib;
                r_count <= n_count;
                r_exh   <= n_exh;
                r_term  <= n_term;
            end
        end
    end

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.finish) |=>
            (r_phase == PH_BETWEEN && r_count == 8'd0 && !r_term && !r_exh))
        else $error("scan state not cleared after finish");

    a_two_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.count == 2'd2) |-> (i_accept && i_item.finish))
        else $error("two results from an item that is not a finish");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= TL_MAX)
        else $error("text length passed its saturation value");

endmodule

// ===== rtl/core/skwa_out_queue.sv =====
// Result queue for the keyword assembler: takes up to two results per cycle
// and delivers one per transfer. Depends on skwa_pkg and skwa_stream_if.
module skwa_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  skwa_pkg::t_emit  i_push,
    output logic             o_space_ok,
    skwa_stream_if.source    o_out
);
    import skwa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(QUEUE_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_out_item        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr,    n_wr;
    logic [PTR_W-1:0] r_rd,    n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    // Room for two results is kept so a finish item never stalls mid-write.
    assign o_space_ok  = (r_count <= CNT_ROOM);
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_mem[r_rd];
    assign pop         = o_out.valid && o_out.ready;

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.count);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= CNT_ROOM))
        else $error("results pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop after a transfer");

endmodule

// ===== rtl/core/stack_code_keyword_assembler.sv =====
// Top level of the stack code keyword assembler.
// Depends on skwa_pkg, skwa_stream_if, skwa_scan and skwa_out_queue.
//
//  Channel     Dir  Handshake          Payload
//  i_in        in   valid/ready        symbol[7:0], finish
//  o_out       out  valid/ready        kind, code_byte[7:0], status[1:0],
//                                      code_count[7:0], last
//  i_cfg_*     in   write enable only  code_capacity[7:0]
//
// One source item is taken per cycle; its results enter a four-entry result
// queue at that edge and the first one can be transferred the cycle after.
// A finish item may yield two results, delivered in two consecutive transfers.
// i_in.ready falls while the queue holds more than two results, so a stalled
// output side throttles the input. Reset is synchronous and needs no sweep.
module stack_code_keyword_assembler #(
    parameter int MAX_TEXT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    skwa_stream_if.sink   i_in,
    skwa_stream_if.source o_out
);
    import skwa_pkg::*;

    logic  accept;
    logic  space_ok;
    t_emit emit;

    assign i_in.ready = space_ok;
    assign accept     = i_in.valid && space_ok;

    skwa_scan #(
        .MAX_TEXT (MAX_TEXT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_in.data),
        .o_emit      (emit)
    );

    skwa_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (emit),
        .o_space_ok (space_ok),
        .o_out      (o_out)
    );

endmodule
